@@ rtl/core/bia_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap index allocator package
// Shared constants, request and status codes, and sequencer state types.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int WORD_BITS_DEF = 64;

    localparam int DATA_W    = 16;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_SHIFT = 24;

    localparam logic [MODE_W-1:0] MODE_CHECK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GET        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UNSET      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND_BELOW = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIND_ABOVE = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_USED    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FREE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 2'd1;

    localparam logic [DATA_W-1:0] RANGE_START_RST = 16'd0;
    localparam logic [DATA_W-1:0] RANGE_END_RST   = 16'd1023;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_FIX,
        S_READ,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_INDEX,
        DIV_FIRST,
        DIV_LAST
    } div_phase_t;

endpackage

@@ rtl/core/bitmap_index_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap index allocator
// Occupancy bitmap over a configurable index window with check, get, set,
// unset and nearest free index search below or above a starting index.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals                          Word
//  s_*      in         tvalid tready tdata tuser        mode, index, bound
//  m_*      out        tvalid tready tdata              status, flags, index
//  cfg_*    in         valid ready index data           register write
//
// A valid check, get, set or unset runs CHECK, MUL, FIX, READ, EXEC and DONE
// after acceptance; the next request is taken back in IDLE. An invalid request
// goes from CHECK to DONE. Searches that scan add divisions for the first and
// last word, then SCAN_RD and SCAN over up to CAPACITY/WORD_BITS words, read
// one at a time on the single RAM read port. After reset CLEAR zeroes the
// bitmap and accepts no request. A stalled output holds the next result in place.
// ----------------------------------------------------------------------------
module bitmap_index_allocator
    import bia_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,    // index [15:0], bound [31:16]
    input  logic [MODE_W-1:0]    s_tuser,    // mode [2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,    // status [1:0], bit_was_set [2],
                                             // found [3], result_index [19:4]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int NWORDS  = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int PROD_W  = DATA_W + DIV_SHIFT;

    localparam logic [DIV_SHIFT-1:0] RECIP     = DIV_SHIFT'((1 << DIV_SHIFT) / WORD_BITS);
    localparam logic [DATA_W:0]      CAP_V     = (DATA_W + 1)'(CAPACITY);
    localparam logic [DATA_W-1:0]    WB_V      = DATA_W'(WORD_BITS);
    localparam logic [WADDR_W-1:0]   LAST_WORD = WADDR_W'(NWORDS - 1);
    localparam logic [BIT_W-1:0]     TOP_BIT   = BIT_W'(WORD_BITS - 1);

    state_t                 state_reg;
    state_t                 state_next;
    div_phase_t             phase_reg;
    logic [WADDR_W-1:0]     clr_cnt_reg;
    logic [DATA_W-1:0]      range_start_reg;
    logic [DATA_W-1:0]      range_end_reg;
    logic                   m_tvalid_reg;
    logic [23:0]            m_tdata_reg;

    logic [MODE_W-1:0]      mode_reg;
    logic [DATA_W-1:0]      index_reg;
    logic [DATA_W-1:0]      bound_reg;
    logic [DATA_W-1:0]      off_i_reg;
    logic [DATA_W-1:0]      off_b_reg;
    logic                   bnd_ok_reg;
    logic                   empty_reg;
    logic [DATA_W-1:0]      div_in_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [WADDR_W-1:0]     wi_reg;
    logic [BIT_W-1:0]       bi_reg;
    logic [WADDR_W-1:0]     cur_w_reg;
    logic [WADDR_W-1:0]     first_w_reg;
    logic [BIT_W-1:0]       first_b_reg;
    logic [WADDR_W-1:0]     last_w_reg;
    logic [BIT_W-1:0]       last_b_reg;
    logic [DATA_W-1:0]      base_reg;
    logic [STATUS_W-1:0]    res_status_reg;
    logic                   res_was_reg;
    logic                   res_found_reg;
    logic [DATA_W-1:0]      res_index_reg;

    logic                   ram_we;
    logic [WADDR_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [WADDR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]   rd_data;

    logic                   in_accept;
    logic                   out_free;
    logic [DATA_W-1:0]      off_i;
    logic [DATA_W-1:0]      off_b;
    logic                   idx_ok;
    logic                   bnd_ok;
    logic                   mode_bad;
    logic                   below;
    logic                   empty;
    logic [DATA_W-1:0]      q_est;
    logic [DATA_W-1:0]      r_est;
    logic                   q_fix;
    logic [DATA_W-1:0]      q_val;
    logic [DATA_W-1:0]      r_val;
    logic [DATA_W-1:0]      base_val;
    logic                   was;
    logic [WORD_BITS-1:0]   bit_mask;
    logic [BIT_W-1:0]       lo;
    logic [BIT_W-1:0]       hi;
    logic [WORD_BITS-1:0]   scan_mask;
    logic [WORD_BITS-1:0]   free_bits;
    logic                   hit;
    logic [BIT_W-1:0]       hit_bit;
    logic                   at_last;
    logic [WADDR_W-1:0]     next_w;

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Window checks on the latched request.
    assign off_i    = index_reg - range_start_reg;
    assign off_b    = bound_reg - range_start_reg;
    assign idx_ok   = (index_reg >= range_start_reg) && (index_reg <= range_end_reg)
                      && ({1'b0, off_i} < CAP_V);
    assign bnd_ok   = (bound_reg >= range_start_reg) && (bound_reg <= range_end_reg)
                      && ({1'b0, off_b} < CAP_V);
    assign mode_bad = mode_reg > MODE_FIND_ABOVE;
    assign below    = mode_reg == MODE_FIND_BELOW;
    assign empty    = below ? (index_reg <= bound_reg) : (index_reg >= bound_reg);

    // Division by the word size: reciprocal estimate, then one correction step.
    assign q_est    = prod_reg[PROD_W-1:DIV_SHIFT];
    assign r_est    = div_in_reg - DATA_W'(q_est * WB_V);
    assign q_fix    = r_est >= WB_V;
    assign q_val    = q_fix ? (q_est + 16'd1) : q_est;
    assign r_val    = q_fix ? (r_est - WB_V) : r_est;
    assign base_val = div_in_reg - r_val;

    assign was      = rd_data[bi_reg];
    assign bit_mask = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bi_reg;

    // Scan of one bitmap word.
    assign at_last = cur_w_reg == last_w_reg;
    assign next_w  = below ? (cur_w_reg - 1'b1) : (cur_w_reg + 1'b1);

    always_comb
    begin
        if (below)
        begin
            hi = (cur_w_reg == first_w_reg) ? first_b_reg : TOP_BIT;
            lo = at_last ? last_b_reg : '0;
        end
        else
        begin
            lo = (cur_w_reg == first_w_reg) ? first_b_reg : '0;
            hi = at_last ? last_b_reg : TOP_BIT;
        end
    end

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            scan_mask[i] = (BIT_W'(i) >= lo) && (BIT_W'(i) <= hi);
        end
    end

    assign free_bits = ~rd_data & scan_mask;

    always_comb
    begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (free_bits[i] && (below || !hit))
            begin
                hit_bit = BIT_W'(i);
            end
            hit = hit || free_bits[i];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (mode_bad || !idx_ok) ? S_DONE : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_FIX;
            end
            S_FIX:
            begin
                unique case (phase_reg)
                    DIV_INDEX: state_next = S_READ;
                    DIV_FIRST: state_next = S_MUL;
                    DIV_LAST:  state_next = S_SCAN_RD;
                    default:   state_next = S_DONE;
                endcase
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                if ((mode_reg == MODE_FIND_BELOW || mode_reg == MODE_FIND_ABOVE)
                    && bnd_ok_reg && !empty_reg)
                begin
                    state_next = S_MUL;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit || at_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshake and memory ports.
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = wi_reg;
        ram_wdata = rd_data;
        ram_raddr = wi_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_EXEC:
            begin
                if (mode_reg == MODE_SET && !was)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_data | bit_mask;
                end
                else if (mode_reg == MODE_UNSET && was)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_data & ~bit_mask;
                end
            end
            S_SCAN_RD:
            begin
                ram_raddr = cur_w_reg;
            end
            S_SCAN:
            begin
                ram_raddr = (hit || at_last) ? cur_w_reg : next_w;
            end
            default:
            begin
                ram_raddr = wi_reg;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            range_start_reg <= RANGE_START_RST;
            range_end_reg   <= RANGE_END_RST;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_RANGE_START: range_start_reg <= cfg_data;
                    CFG_RANGE_END:   range_end_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            if (state_reg == S_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    mode_reg  <= s_tuser;
                    index_reg <= s_tdata[15:0];
                    bound_reg <= s_tdata[31:16];
                end
            end
            S_CHECK:
            begin
                off_i_reg      <= off_i;
                off_b_reg      <= off_b;
                bnd_ok_reg     <= bnd_ok;
                empty_reg      <= empty;
                div_in_reg     <= off_i;
                phase_reg      <= DIV_INDEX;
                res_status_reg <= (mode_bad || !idx_ok) ? STATUS_INVALID : STATUS_OK;
                res_was_reg    <= 1'b0;
                res_found_reg  <= 1'b0;
                res_index_reg  <= '0;
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(div_in_reg) * PROD_W'(RECIP);
            end
            S_FIX:
            begin
                unique case (phase_reg)
                    DIV_INDEX:
                    begin
                        wi_reg <= q_val[WADDR_W-1:0];
                        bi_reg <= r_val[BIT_W-1:0];
                    end
                    DIV_FIRST:
                    begin
                        cur_w_reg   <= q_val[WADDR_W-1:0];
                        first_w_reg <= q_val[WADDR_W-1:0];
                        first_b_reg <= r_val[BIT_W-1:0];
                        base_reg    <= base_val;
                        div_in_reg  <= off_b_reg;
                        phase_reg   <= DIV_LAST;
                    end
                    DIV_LAST:
                    begin
                        last_w_reg <= q_val[WADDR_W-1:0];
                        last_b_reg <= r_val[BIT_W-1:0];
                    end
                    default:
                    begin
                        phase_reg <= DIV_INDEX;
                    end
                endcase
            end
            S_EXEC:
            begin
                res_was_reg <= was;
                case (mode_reg)
                    MODE_SET:
                    begin
                        if (was)
                        begin
                            res_status_reg <= STATUS_USED;
                        end
                    end
                    MODE_UNSET:
                    begin
                        if (!was)
                        begin
                            res_status_reg <= STATUS_FREE;
                        end
                    end
                    MODE_FIND_BELOW, MODE_FIND_ABOVE:
                    begin
                        if (!bnd_ok_reg)
                        begin
                            res_status_reg <= STATUS_INVALID;
                        end
                        div_in_reg <= below ? (off_i_reg - 16'd1) : (off_i_reg + 16'd1);
                        phase_reg  <= DIV_FIRST;
                    end
                    default:
                    begin
                        res_status_reg <= res_status_reg;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_found_reg <= 1'b1;
                    res_index_reg <= range_start_reg + base_reg + DATA_W'(hit_bit);
                end
                else if (!at_last)
                begin
                    cur_w_reg <= next_w;
                    base_reg  <= below ? (base_reg - WB_V) : (base_reg + WB_V);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {4'd0, res_index_reg, res_found_reg, res_was_reg,
                                    res_status_reg};
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_ram_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr <= LAST_WORD))
        else $error("bitmap write beyond the last word");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("request accepted during the clearing pass");

    a_found_only_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_found_reg) |->
            (res_status_reg == STATUS_OK
             && (mode_reg == MODE_FIND_BELOW || mode_reg == MODE_FIND_ABOVE)))
        else $error("found flag set outside a successful search");

    a_found_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_found_reg) |->
            (res_index_reg >= range_start_reg && res_index_reg <= range_end_reg))
        else $error("search returned an index outside the window");
`endif

endmodule

@@ rtl/core/bia_ram.sv @@
// ----------------------------------------------------------------------------
// Bitmap index allocator RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module bia_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ tb/bia_result_checker.sv @@
// ----------------------------------------------------------------------------
// Bitmap index allocator result checker
// Watches the request, result and register channels, predicts each result from
// its own copy of the window and the occupancy bitmap, and compares field by
// field in order.
// ----------------------------------------------------------------------------
module bia_result_checker
    import bia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,    // index [15:0], bound [31:16]
    input  logic [MODE_W-1:0]    s_tuser,    // mode [2:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [23:0]          m_tdata,    // status [1:0], bit_was_set [2],
                                             // found [3], result_index [19:4]
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   errors,
    output int                   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                was_set;
        logic                found;
        logic [DATA_W-1:0]   free_index;
    } alloc_result_t;

    logic [CAPACITY_DEF-1:0] occupied;
    int unsigned             win_lo;
    int unsigned             win_hi;
    alloc_result_t           awaited_results[$];
    alloc_result_t           want;

    function automatic bit in_window(int unsigned x);
        return x >= win_lo && x <= win_hi && (x - win_lo) < CAPACITY_DEF;
    endfunction

    function automatic alloc_result_t predict_alloc(logic [MODE_W-1:0] mode_code,
                                                    logic [DATA_W-1:0] idx,
                                                    logic [DATA_W-1:0] bnd);
        alloc_result_t r;
        int unsigned   x;
        r = '0;
        if (mode_code > MODE_FIND_ABOVE || !in_window(idx)) begin
            r.status = STATUS_INVALID;
        end
        else begin
            r.was_set = occupied[idx - win_lo];
            case (mode_code)
                MODE_SET:
                    if (r.was_set)
                        r.status = STATUS_USED;
                    else
                        occupied[idx - win_lo] = 1'b1;
                MODE_UNSET:
                    if (!r.was_set)
                        r.status = STATUS_FREE;
                    else
                        occupied[idx - win_lo] = 1'b0;
                MODE_FIND_BELOW:
                    if (!in_window(bnd)) begin
                        r.status = STATUS_INVALID;
                    end
                    else begin
                        x = idx;
                        while (x > bnd && !r.found) begin
                            x--;
                            if (!occupied[x - win_lo]) begin
                                r.found      = 1'b1;
                                r.free_index = DATA_W'(x);
                            end
                        end
                    end
                MODE_FIND_ABOVE:
                    if (!in_window(bnd)) begin
                        r.status = STATUS_INVALID;
                    end
                    else begin
                        x = idx;
                        while (x < bnd && !r.found) begin
                            x++;
                            if (!occupied[x - win_lo]) begin
                                r.found      = 1'b1;
                                r.free_index = DATA_W'(x);
                            end
                        end
                    end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned expected_val,
                               input int unsigned actual_val);
        if (expected_val != actual_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, field, expected_val, actual_val);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            occupied    = '0;
            win_lo      = RANGE_START_RST;
            win_hi      = RANGE_END_RST;
            awaited_results.delete();
            outstanding = 0;
            errors      = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RANGE_START: win_lo = cfg_data;
                    CFG_RANGE_END:   win_hi = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(predict_alloc(s_tuser, s_tdata[15:0],
                                                        s_tdata[31:16]));
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: result word with no request pending, actual %h",
                             $time, m_tdata);
                end
                else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, m_tdata[1:0]);
                    check_field("bit_was_set", want.was_set, m_tdata[2]);
                    check_field("found", want.found, m_tdata[3]);
                    check_field("result_index", want.free_index, m_tdata[19:4]);
                end
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Bitmap index allocator testbench
// Drives directed and random requests through several index windows, with
// random gaps on both channels and one long output stall, and reports the
// verdict from the result checker.
// ----------------------------------------------------------------------------
module tb
    import bia_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0]    MODE_RSVD_LO = 3'd6;
    localparam logic [MODE_W-1:0]    MODE_RSVD_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
    localparam int                   STALL_LIMIT  = 2000;
    localparam int                   HOLD_CYCLES  = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;    // index [15:0], bound [31:16]
    logic [MODE_W-1:0]    s_tuser;    // mode [2:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;    // status [1:0], bit_was_set [2],
                                      // found [3], result_index [19:4]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    int          errors;
    int          outstanding;
    int          items_sent = 0;
    int          stall_cycles = 0;
    int unsigned cur_lo;
    int unsigned cur_hi;
    bit          held = 1'b0;
    wire         calm = items_sent >= 700 && items_sent < 1000;

    bitmap_index_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bia_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // The output side stalls at random, and once holds off long enough for
    // the request side to back up.
    initial begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && items_sent >= 500) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= calm || $urandom_range(0, 99) >= 19;
        end
    end

    function automatic logic [DATA_W-1:0] window_top();
        return DATA_W'((cur_hi < cur_lo + CAPACITY_DEF - 1) ? cur_hi
                                                            : cur_lo + CAPACITY_DEF - 1);
    endfunction

    function automatic logic [DATA_W-1:0] pick_index();
        int unsigned r;
        int unsigned span;
        r = $urandom_range(0, 99);
        span = (cur_hi >= cur_lo) ? cur_hi - cur_lo : 0;
        if (span >= CAPACITY_DEF)
            span = CAPACITY_DEF - 1;
        if (r < 75)
            return DATA_W'(cur_lo + $urandom_range(0, span));
        if (r < 88) begin
            case ($urandom_range(0, 3))
                0:       return DATA_W'(cur_lo);
                1:       return DATA_W'(cur_hi);
                2:       return DATA_W'(cur_lo - 1);
                default: return DATA_W'(cur_lo + CAPACITY_DEF);
            endcase
        end
        return DATA_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_request(input logic [MODE_W-1:0] mode_code,
                                input logic [DATA_W-1:0] idx,
                                input logic [DATA_W-1:0] bnd);
        while (!calm && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bnd, idx};
        s_tuser  <= mode_code;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx,
                             input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (reg_idx == CFG_RANGE_START)
            cur_lo = value;
        else if (reg_idx == CFG_RANGE_END)
            cur_hi = value;
        @(negedge clk);
    endtask

    task automatic single_request();
        int unsigned       r;
        logic [MODE_W-1:0] mode_code;
        logic [DATA_W-1:0] bnd;
        r = $urandom_range(0, 99);
        if (r < 8)
            mode_code = MODE_CHECK;
        else if (r < 16)
            mode_code = MODE_GET;
        else if (r < 42)
            mode_code = MODE_SET;
        else if (r < 62)
            mode_code = MODE_UNSET;
        else if (r < 80)
            mode_code = MODE_FIND_BELOW;
        else if (r < 97)
            mode_code = MODE_FIND_ABOVE;
        else
            mode_code = r[0] ? MODE_RSVD_LO : MODE_RSVD_HI;
        if ($urandom_range(0, 1))
            bnd = pick_index();
        else
            bnd = (mode_code == MODE_FIND_BELOW) ? DATA_W'(cur_lo) : window_top();
        send_request(mode_code, pick_index(), bnd);
    endtask

    // A run marks or frees consecutive indices, then searches across it.
    task automatic run_request();
        int unsigned       len;
        logic [DATA_W-1:0] base;
        logic [MODE_W-1:0] mode_code;
        len = $urandom_range(4, 96);
        base = pick_index();
        mode_code = ($urandom_range(0, 99) < 60) ? MODE_SET : MODE_UNSET;
        for (int unsigned k = 0; k < len; k++)
            send_request(mode_code, DATA_W'(base + k), DATA_W'($urandom_range(0, 65535)));
        if ($urandom_range(0, 1))
            send_request(MODE_FIND_ABOVE, base - 1'b1, window_top());
        else
            send_request(MODE_FIND_BELOW, DATA_W'(base + len), DATA_W'(cur_lo));
    endtask

    task automatic random_traffic(input int quota);
        int          stop_at;
        int unsigned r;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 25)
                run_request();
            else if (r < 92)
                single_request();
            else
                send_request(MODE_W'($urandom_range(0, 7)),
                             DATA_W'($urandom_range(0, 65535)),
                             DATA_W'($urandom_range(0, 65535)));
        end
    endtask

    task automatic window_phase(input int unsigned lo, input int unsigned hi,
                                input int quota);
        drain_requests();
        write_reg(CFG_RANGE_START, DATA_W'(lo));
        write_reg(CFG_RANGE_END, DATA_W'(hi));
        random_traffic(quota);
    endtask

    initial begin
        int unsigned lo;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cur_lo    = RANGE_START_RST;
        cur_hi    = RANGE_END_RST;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(MODE_CHECK, 16'd0, 16'd0);
        send_request(MODE_CHECK, 16'd1023, 16'd0);
        send_request(MODE_CHECK, 16'd1024, 16'd0);
        send_request(MODE_GET, 16'hFFFF, 16'hFFFF);
        send_request(MODE_GET, 16'd5, 16'd0);
        send_request(MODE_SET, 16'd0, 16'd0);
        send_request(MODE_SET, 16'd0, 16'd0);
        send_request(MODE_SET, 16'd1023, 16'd0);
        send_request(MODE_SET, 16'd1022, 16'd0);
        send_request(MODE_GET, 16'd1023, 16'd0);
        send_request(MODE_UNSET, 16'd1022, 16'd0);
        send_request(MODE_UNSET, 16'd1022, 16'd0);
        send_request(MODE_FIND_BELOW, 16'd1, 16'd0);
        send_request(MODE_FIND_BELOW, 16'd10, 16'd0);
        send_request(MODE_FIND_ABOVE, 16'd1021, 16'd1023);
        send_request(MODE_FIND_ABOVE, 16'd1022, 16'd1023);
        send_request(MODE_FIND_ABOVE, 16'd5, 16'd2000);
        send_request(MODE_FIND_BELOW, 16'd2000, 16'd5);
        send_request(MODE_FIND_BELOW, 16'd5, 16'd5);
        send_request(MODE_FIND_ABOVE, 16'd9, 16'd3);
        send_request(MODE_FIND_ABOVE, 16'd0, 16'd1023);
        send_request(MODE_FIND_BELOW, 16'd1023, 16'd0);
        send_request(MODE_RSVD_LO, 16'd0, 16'd0);
        send_request(MODE_RSVD_HI, 16'hFFFF, 16'hFFFF);

        random_traffic(350);
        window_phase(0, 65535, 250);
        window_phase(65280, 65535, 250);
        window_phase(64512, 65535, 250);
        drain_requests();
        write_reg(CFG_SPARE, DATA_W'($urandom_range(0, 65535)));
        window_phase(200, 100, 60);
        window_phase(65535, 65535, 60);
        window_phase(0, 0, 60);
        repeat (2) begin
            lo = $urandom_range(0, 65535);
            window_phase(lo, (lo + $urandom_range(0, 1500) > 65535)
                             ? 65535 : lo + $urandom_range(0, 1500), 200);
        end

        drain_requests();
        repeat (40) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bia_pkg.sv
rtl/core/bia_ram.sv
rtl/core/bitmap_index_allocator.sv
tb/bia_result_checker.sv
tb/tb.sv
